// File: rtl/core/dexl_pkg.sv
// Shared token codes, class values and the ROLL keyword for the dice expression lexer.
package dexl_pkg;

	localparam int unsigned KIND_W  = 4;
	localparam int unsigned VALUE_W = 31;
	localparam int unsigned GROUP_N = 3;

	localparam logic [KIND_W-1:0] K_START = 4'd0;
	localparam logic [KIND_W-1:0] K_END   = 4'd1;
	localparam logic [KIND_W-1:0] K_ADD   = 4'd2;
	localparam logic [KIND_W-1:0] K_SUB   = 4'd3;
	localparam logic [KIND_W-1:0] K_MUL   = 4'd4;
	localparam logic [KIND_W-1:0] K_DIV   = 4'd5;
	localparam logic [KIND_W-1:0] K_LBR   = 4'd6;
	localparam logic [KIND_W-1:0] K_RBR   = 4'd7;
	localparam logic [KIND_W-1:0] K_ROLL  = 4'd8;
	localparam logic [KIND_W-1:0] K_DIE   = 4'd9;
	localparam logic [KIND_W-1:0] K_NUM   = 4'd10;

	localparam logic [VALUE_W-1:0] NUM_MAX      = 31'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] CLS_ADDSUB   = 31'd8;
	localparam logic [VALUE_W-1:0] CLS_MULDIV   = 31'd9;
	localparam logic [VALUE_W-1:0] CLS_BRACKET  = 31'd15;
	localparam logic [VALUE_W-1:0] CLS_ROLL     = 31'd1;
	localparam logic [VALUE_W-1:0] IMPLICIT_ONE = 31'd1;

	localparam logic [2:0] ROLL_LEN = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
	} token_t;

	// upper-case letters of the keyword, by position
	function automatic logic [7:0] roll_letter(input logic [1:0] pos);
		logic [7:0] r;
		unique case (pos)
			2'd0: r = 8'h52;
			2'd1: r = 8'h4F;
			2'd2: r = 8'h4C;
			2'd3: r = 8'h4C;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/dice_expression_lexer_unit.sv
// Top level of the dice expression lexer: character input, token output.
//
// Accepts one character per cycle on the ch request channel while the output buffer
// can take its tokens, and emits tokens on the token channel. A character is held in an input
// register and classified against the lexer state; once the buffer is free, its whole
// token group (zero to three tokens) is written into a three-entry output buffer,
// which drains one token per cycle while out_ready is high. A character producing
// several tokens holds off the next one until the last of them is taken; characters
// producing zero or one token sustain one per cycle while out_ready is high. A zero
// byte emits the end token and resets the lexer state. Numbers saturate at 2^31-1.
module dice_expression_lexer_unit
	import dexl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [KIND_W-1:0]  token_kind,
	output logic [VALUE_W-1:0] token_value,
	output logic               last_of_run
);

	// input stage
	logic       valid_s1;
	logic [7:0] ch_s1;

	// lexer state
	logic               at_start_q;
	logic               num_active_q;
	logic [VALUE_W-1:0] num_acc_q;
	logic               word_active_q;
	logic [2:0]         word_cnt_q;
	logic               word_failed_q;
	logic [KIND_W-1:0]  prev_kind_q;

	// output buffer
	token_t     obuf_q [GROUP_N];
	logic [1:0] ocnt_q;

	// classification
	logic               is_digit;
	logic               is_letter;
	logic               is_d;
	logic [7:0]         upper;
	logic               first_v;
	token_t             first_tok;
	logic [KIND_W-1:0]  prev_mid;
	logic               implicit_v;
	logic               op_v;
	token_t             op_tok;
	logic               is_end;
	token_t             grp [GROUP_N];
	logic [1:0]         grp_cnt;
	logic [KIND_W-1:0]  last_kind;
	logic [VALUE_W-1:0] acc_base;
	logic [34:0]        acc_sum;
	logic [VALUE_W-1:0] acc_next;

	logic buf_free;
	logic advance;
	logic load;
	logic pop;

	assign is_digit  = (ch_s1 >= 8'h30) && (ch_s1 <= 8'h39);
	assign is_letter = ((ch_s1 >= 8'h61) && (ch_s1 <= 8'h7A)) ||
		((ch_s1 >= 8'h41) && (ch_s1 <= 8'h5A));
	assign is_d      = (ch_s1 == 8'h64) && !word_active_q;
	assign upper     = (ch_s1 >= 8'h61) ? (ch_s1 - 8'h20) : ch_s1;
	assign is_end    = (ch_s1 == 8'h00);

	// pending start, number or keyword: at most one can be present
	always_comb begin
		first_v   = 1'b0;
		first_tok = '{kind: K_START, value: '0};
		priority if (at_start_q) begin
			first_v = 1'b1;
		end else if (num_active_q && !is_digit) begin
			first_v   = 1'b1;
			first_tok = '{kind: K_NUM, value: num_acc_q};
		end else if (word_active_q && !is_letter && !word_failed_q &&
				(word_cnt_q == ROLL_LEN)) begin
			first_v   = 1'b1;
			first_tok = '{kind: K_ROLL, value: CLS_ROLL};
		end else begin
			first_v = 1'b0;
		end
	end

	assign prev_mid   = first_v ? first_tok.kind : prev_kind_q;
	assign implicit_v = is_d && (prev_mid != K_NUM) && (prev_mid != K_RBR);

	always_comb begin
		op_v   = 1'b1;
		op_tok = '{kind: K_DIE, value: '0};
		if (!is_d) begin
			unique case (ch_s1)
				8'h2B: op_tok = '{kind: K_ADD, value: CLS_ADDSUB};
				8'h2D: op_tok = '{kind: K_SUB, value: CLS_ADDSUB};
				8'h2A: op_tok = '{kind: K_MUL, value: CLS_MULDIV};
				8'h2F: op_tok = '{kind: K_DIV, value: CLS_MULDIV};
				8'h28, 8'h7B, 8'h5B: op_tok = '{kind: K_LBR, value: CLS_BRACKET};
				8'h29, 8'h7D, 8'h5D: op_tok = '{kind: K_RBR, value: CLS_BRACKET};
				8'h00: op_tok = '{kind: K_END, value: '0};
				default: op_v = 1'b0;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < GROUP_N; i++) begin
			grp[i] = '{kind: K_START, value: '0};
		end
		grp_cnt   = 2'd0;
		last_kind = prev_kind_q;
		if (first_v) begin
			grp[grp_cnt] = first_tok;
			last_kind    = first_tok.kind;
			grp_cnt      = grp_cnt + 2'd1;
		end
		if (implicit_v) begin
			grp[grp_cnt] = '{kind: K_NUM, value: IMPLICIT_ONE};
			last_kind    = K_NUM;
			grp_cnt      = grp_cnt + 2'd1;
		end
		if (op_v) begin
			grp[grp_cnt] = op_tok;
			last_kind    = op_tok.kind;
			grp_cnt      = grp_cnt + 2'd1;
		end
	end

	// decimal accumulate, acc*10 + digit with saturation
	assign acc_base = num_active_q ? num_acc_q : '0;
	assign acc_sum  = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) +
		{31'b0, ch_s1[3:0]};
	assign acc_next = (|acc_sum[34:31]) ? NUM_MAX : acc_sum[VALUE_W-1:0];

	assign pop      = out_valid && out_ready;
	assign buf_free = (ocnt_q == 2'd0) || (pop && (ocnt_q == 2'd1));
	assign advance  = valid_s1 && ((grp_cnt == 2'd0) || buf_free);
	assign load     = advance && (grp_cnt != 2'd0);
	assign in_ready = !valid_s1 || advance;

	assign out_valid   = (ocnt_q != 2'd0);
	assign token_kind  = obuf_q[0].kind;
	assign token_value = obuf_q[0].value;
	assign last_of_run = (ocnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q    <= 1'b1;
			num_active_q  <= 1'b0;
			num_acc_q     <= '0;
			word_active_q <= 1'b0;
			word_cnt_q    <= '0;
			word_failed_q <= 1'b0;
			prev_kind_q   <= K_START;
		end else if (advance) begin
			if (is_end) begin
				at_start_q    <= 1'b1;
				num_active_q  <= 1'b0;
				num_acc_q     <= '0;
				word_active_q <= 1'b0;
				word_cnt_q    <= '0;
				word_failed_q <= 1'b0;
				prev_kind_q   <= K_START;
			end else begin
				at_start_q  <= 1'b0;
				prev_kind_q <= last_kind;
				if (is_digit) begin
					num_active_q <= 1'b1;
					num_acc_q    <= acc_next;
				end else begin
					num_active_q <= 1'b0;
					num_acc_q    <= '0;
				end
				if (is_letter && !is_d) begin
					word_active_q <= 1'b1;
					if (!word_failed_q && (word_cnt_q < ROLL_LEN)) begin
						if (upper == roll_letter(word_cnt_q[1:0])) begin
							word_cnt_q <= word_cnt_q + 3'd1;
						end else begin
							word_failed_q <= 1'b1;
						end
					end
				end else if (!is_letter) begin
					word_active_q <= 1'b0;
					word_cnt_q    <= '0;
					word_failed_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
		end else if (load) begin
			ocnt_q <= grp_cnt;
		end else if (pop) begin
			ocnt_q <= ocnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < GROUP_N; i++) begin
				obuf_q[i] <= grp[i];
			end
		end else if (pop) begin
			obuf_q[0] <= obuf_q[1];
			obuf_q[1] <= obuf_q[2];
		end
	end

`ifndef ASSERT_OFF
	a_runs_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(num_active_q && word_active_q))
		else $error("number and letter run active together");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		at_start_q |-> (!num_active_q && !word_active_q))
		else $error("run pending at expression start");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_end) |=> (at_start_q && (prev_kind_q == K_START)))
		else $error("end of expression did not reset lexer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && out_ready)))
		else $error("token group overwrote undelivered tokens");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking testbench for dice_expression_lexer_unit: random character stream, token predictor.
`timescale 1ns / 1ps

module testbench;
	import dexl_pkg::*;

	localparam logic [7:0]  END_CHAR     = 8'h00;
	localparam logic [31:0] ROLL_TEXT    = "ROLL";
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned MAX_PRINTS   = 40;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               last_flag;
	} token_exp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         ch = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [KIND_W-1:0]  token_kind;
	logic [VALUE_W-1:0] token_value;
	logic               last_of_run;

	dice_expression_lexer_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.token_value (token_value),
		.last_of_run (last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// lexer state as predicted
	logic               lex_at_start;
	logic               lex_num_active;
	logic [VALUE_W-1:0] lex_num_acc;
	logic               lex_word_active;
	logic [2:0]         lex_word_count;
	logic               lex_word_failed;
	logic [KIND_W-1:0]  lex_prev_kind;

	token_exp_t char_tokens[$];
	token_exp_t token_q[$];
	token_exp_t want;

	int unsigned cycle_count = 0;
	int unsigned chars_accepted = 0;
	int unsigned expressions_closed = 0;
	int unsigned tokens_checked = 0;
	int unsigned numbers_seen = 0;
	int unsigned rolls_seen = 0;
	int unsigned dice_seen = 0;
	int unsigned mismatch_count = 0;
	int          ready_hold = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;

	function automatic void lex_reset();
		lex_at_start    = 1'b1;
		lex_num_active  = 1'b0;
		lex_num_acc     = '0;
		lex_word_active = 1'b0;
		lex_word_count  = '0;
		lex_word_failed = 1'b0;
		lex_prev_kind   = K_START;
	endfunction

	function automatic void emit_token(input logic [KIND_W-1:0] kind,
			input logic [VALUE_W-1:0] value);
		token_exp_t t;
		if (char_tokens.size() < GROUP_N) begin
			t.kind      = kind;
			t.value     = value;
			t.last_flag = 1'b0;
			char_tokens.push_back(t);
			lex_prev_kind = kind;
		end
	endfunction

	function automatic void lex_predict(input logic [7:0] c);
		token_exp_t t;
		logic       is_digit;
		logic       is_alpha;
		logic [7:0] up;
		logic [31:0] dval;
		is_digit = (c >= "0") && (c <= "9");
		is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
		char_tokens.delete();
		if (lex_at_start) begin
			emit_token(K_START, '0);
			lex_at_start = 1'b0;
		end
		if (lex_num_active && !is_digit) begin
			emit_token(K_NUM, lex_num_acc);
			lex_num_active = 1'b0;
			lex_num_acc    = '0;
		end
		if (lex_word_active && !is_alpha) begin
			if (!lex_word_failed && lex_word_count == ROLL_LEN)
				emit_token(K_ROLL, CLS_ROLL);
			lex_word_active = 1'b0;
			lex_word_count  = '0;
			lex_word_failed = 1'b0;
		end
		if (is_digit) begin
			dval = 32'(c - "0");
			if (!lex_num_active) begin
				lex_num_active = 1'b1;
				lex_num_acc    = '0;
			end
			if (32'(lex_num_acc) > (32'(NUM_MAX) - dval) / 32'd10)
				lex_num_acc = NUM_MAX;
			else
				lex_num_acc = VALUE_W'(32'(lex_num_acc) * 32'd10 + dval);
		end else if (c == "d" && !lex_word_active) begin
			if (lex_prev_kind != K_NUM && lex_prev_kind != K_RBR)
				emit_token(K_NUM, IMPLICIT_ONE);
			emit_token(K_DIE, '0);
		end else if (is_alpha) begin
			up = (c >= "a") ? c - 8'h20 : c;
			lex_word_active = 1'b1;
			if (!lex_word_failed && lex_word_count < ROLL_LEN) begin
				if (up == ROLL_TEXT[31 - 8 * lex_word_count -: 8])
					lex_word_count = lex_word_count + 3'd1;
				else
					lex_word_failed = 1'b1;
			end
		end else begin
			case (c)
				"+": emit_token(K_ADD, CLS_ADDSUB);
				"-": emit_token(K_SUB, CLS_ADDSUB);
				"*": emit_token(K_MUL, CLS_MULDIV);
				"/": emit_token(K_DIV, CLS_MULDIV);
				"(", "{", "[": emit_token(K_LBR, CLS_BRACKET);
				")", "}", "]": emit_token(K_RBR, CLS_BRACKET);
				END_CHAR: begin
					emit_token(K_END, '0);
					lex_reset();
				end
				default: ;
			endcase
		end
		foreach (char_tokens[i]) begin
			t = char_tokens[i];
			t.last_flag = (i == char_tokens.size() - 1);
			token_q.push_back(t);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_count++;
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
			ready_hold = $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// token checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (token_q.size() == 0) begin
				report_mismatch($sformatf("unexpected token kind %0d value %0d",
					token_kind, token_value));
			end else begin
				want = token_q.pop_front();
				if (token_kind !== want.kind)
					report_mismatch($sformatf("token_kind %0d, want %0d",
						token_kind, want.kind));
				if (token_value !== want.value)
					report_mismatch($sformatf("token_value %0d, want %0d (kind %0d)",
						token_value, want.value, want.kind));
				if (last_of_run !== want.last_flag)
					report_mismatch($sformatf("last_of_run %0b, want %0b (kind %0d)",
						last_of_run, want.last_flag, want.kind));
				case (want.kind)
					K_NUM:  numbers_seen++;
					K_ROLL: rolls_seen++;
					K_DIE:  dice_seen++;
					default: ;
				endcase
				tokens_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens pending", cycle_count,
				token_q.size());
			$display("dice_expression_lexer_unit verification failed");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] c);
		int gap;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		do @(posedge clk); while (!in_ready);
		lex_predict(c);
		chars_accepted++;
		if (c == END_CHAR)
			expressions_closed++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	task automatic send_digits(input int n);
		for (int i = 0; i < n; i++)
			send_char(pick_char("0123456789"));
	endtask

	task automatic send_random_expression();
		int pieces;
		int extra;
		logic [7:0] c;
		pieces = $urandom_range(2, 10);
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4:
					send_digits(($urandom_range(0, 15) == 0) ? $urandom_range(10, 12)
						: $urandom_range(1, 3));
				5, 6, 7: begin
					send_char("d");
					if ($urandom_range(0, 1)) send_digits($urandom_range(1, 2));
				end
				8, 9, 10: send_char(pick_char("+-*/"));
				11, 12:   send_char(pick_char("({[)}]"));
				13, 14: begin
					for (int k = 0; k < 4; k++) begin
						c = ROLL_TEXT[31 - 8 * k -: 8];
						if ($urandom_range(0, 11) == 0)
							c = pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ");
						send_char(c | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
					end
					extra = $urandom_range(0, 2);
					for (int k = 0; k < extra; k++)
						send_char(pick_char("dDxyzQ"));
				end
				15: send_char(pick_char(" \t.,=!~_"));
				16: begin
					extra = $urandom_range(1, 4);
					for (int k = 0; k < extra; k++)
						send_char(pick_char("abcdefghijklmnopqrstuvwxyzRLO"));
				end
				17: send_char(8'($urandom_range(1, 255)));
				18: send_char("D");
				default: send_char(8'($urandom_range(128, 255)));
			endcase
		end
		if ($urandom_range(0, 7) != 0)
			send_char(END_CHAR);
	endtask

	// operators, every bracket, die with and without the implicit count
	task automatic test_operators_brackets();
		send_text("d)d{2d[(}]*/-+");
		send_char(END_CHAR);
	endtask

	// keyword with trailing d, saturating number, upper-case D, high bytes
	task automatic test_words_numbers();
		send_text("RoLLd4294967296D");
		send_char(8'h80);
		send_char(8'hFF);
		send_char(END_CHAR);
	endtask

	task automatic test_random_stream();
		while (chars_accepted < 300) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			send_random_expression();
		end
	endtask

	// sender holds off until the output side has caught up, mid-expression too
	task automatic test_drain_pause();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_text("12");
		wait_drained();
		send_text("3d");
		wait_drained();
		send_text("(rOlL");
		wait_drained();
		send_text(")");
		send_char(END_CHAR);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		int target;
		target = chars_accepted + 40;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		while (chars_accepted < target)
			send_random_expression();
		send_char(END_CHAR);
	endtask

	initial begin
		lex_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_operators_brackets();
		test_words_numbers();
		test_random_stream();
		test_drain_pause();
		test_back_to_back();
		wait_drained();
		$display("sent %0d characters in %0d expressions; checked %0d tokens", chars_accepted,
			expressions_closed, tokens_checked);
		$display("tokens included %0d numbers, %0d roll keywords, %0d dice; %0d mismatches",
			numbers_seen, rolls_seen, dice_seen, mismatch_count);
		if (mismatch_count == 0 && token_q.size() == 0)
			$display("dice_expression_lexer_unit verification clean");
		else
			$display("dice_expression_lexer_unit verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/dexl_pkg.sv
rtl/core/dice_expression_lexer_unit.sv
bench/testbench.sv
